// File: rtl/mmfs_pkg.sv
// Package for the min-max feature scaler: operation and status codes,
// field widths and pipeline control types. No dependencies.
package mmfs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned ColW = 6;
  localparam int unsigned Columns = 64;
  localparam int unsigned RegIdxW = 1;

  typedef enum logic [FuncW-1:0] {
    FUNC_FIT = 2'd0,
    FUNC_XFORM = 2'd1,
    FUNC_INV = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK = 2'd0,
    STAT_NOT_FITTED = 2'd1,
    STAT_DIV_ZERO = 2'd2,
    STAT_RSVD = 2'd3
  } status_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_RANGE_LOW = 1'd0,
    REG_RANGE_HIGH = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Divider request: magnitude dividend/divisor.
  typedef struct packed {
    logic        start;
    logic [65:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [65:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/mmfs_if.sv
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload type set by parameter.
interface mmfs_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mmfs_div.sv
// Radix-2 restoring divider, 66-bit dividend over 33-bit divisor, one bit per cycle.
// Uses mmfs_pkg for the request and response structs.
module mmfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mmfs_pkg::div_req_t req,
  output mmfs_pkg::div_rsp_t rsp
);
  import mmfs_pkg::*;

  logic [65:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] shifted;
  logic [34:0] diff;

  always_comb begin
    shifted = {rem_r[32:0], quo_r[65]};
    diff = {1'b0, shifted} - {2'b00, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 7'd66;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[34]) begin
        rem_nxt = diff[33:0];
        quo_nxt = {quo_r[64:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[64:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule

// File: rtl/mmfs_store.sv
// Column min/max store: two synchronous memories with registered reads.
// Uses mmfs_pkg for widths.
module mmfs_store #(
  parameter int unsigned COLUMNS = 64,
  parameter int unsigned AW = 6
) (
  input  logic                       clk,
  input  logic [AW-1:0]              rd_addr,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mmfs_pkg::DataW-1:0] wr_min,
  input  logic [mmfs_pkg::DataW-1:0] wr_max,
  output logic [mmfs_pkg::DataW-1:0] rd_min,
  output logic [mmfs_pkg::DataW-1:0] rd_max
);
  import mmfs_pkg::*;

  logic [DataW-1:0] min_mem [COLUMNS];
  logic [DataW-1:0] max_mem [COLUMNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      min_mem[wr_addr] <= wr_min;
      max_mem[wr_addr] <= wr_max;
    end
    rd_min <= min_mem[rd_addr];
    rd_max <= max_mem[rd_addr];
  end
endmodule

// File: rtl/min_max_feature_scaler.sv
// Min-max feature scaler, signed Q16.16, 64 columns. One request at a time: a
// fit steps through read, compare and write back, hand off and idle; transform
// and inverse, when fitted with a nonzero span, pass through the 66-step
// bit-serial divider. A stalled result receiver holds the block in hand off.
// Column stores are synchronous memories with registered reads; no clearing pass.
// Depends on mmfs_pkg, mmfs_if, mmfs_store and mmfs_div.
module min_max_feature_scaler (
  input logic clk,
  input logic rst_n,
  mmfs_if.sink   in_ch,
  mmfs_if.source out_ch,
  mmfs_if.sink   cfg_ch
);
  import mmfs_pkg::*;

  localparam int unsigned AW = ColW;

  // in_ch.data: {func, column, sample_value, first_row}
  // out_ch.data: {scaled_value, status}
  // cfg_ch.data: {index, value}
  logic [FuncW-1:0] in_func;
  logic [ColW-1:0]  in_column;
  logic [DataW-1:0] in_sample;
  logic             in_first;
  assign {in_func, in_column, in_sample, in_first} = in_ch.data;

  logic             cfg_idx;
  logic [DataW-1:0] cfg_val;
  assign {cfg_idx, cfg_val} = cfg_ch.data;

  state_t state_r, state_nxt;

  logic signed [DataW-1:0] lo_r, hi_r;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= 32'sd65536;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (reg_idx_t'(cfg_idx))
        REG_RANGE_LOW:  lo_r <= cfg_val;
        REG_RANGE_HIGH: hi_r <= cfg_val;
        default: ;
      endcase
    end
  end

  logic              fitted_r;
  func_t             func_r;
  logic [AW-1:0]     col_r;
  logic signed [DataW-1:0] x_r;
  logic              first_r;
  logic signed [33:0] a_r, m_r, d_r, add_r;
  logic              neg_r;
  logic signed [DataW-1:0] res_r;
  status_t           stat_r;
  logic              ovalid_r;

  logic [DataW-1:0] rd_min, rd_max;
  logic             wr_en;
  logic [DataW-1:0] wr_min, wr_max;
  div_req_t dreq;
  div_rsp_t drsp;

  mmfs_store #(.COLUMNS(Columns), .AW(AW)) u_store (
    .clk(clk), .rd_addr(col_r), .wr_en(wr_en), .wr_addr(col_r),
    .wr_min(wr_min), .wr_max(wr_max), .rd_min(rd_min), .rd_max(rd_max)
  );

  mmfs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  wire in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: begin
        if (func_r == FUNC_FIT || func_r == FUNC_NOP || !fitted_r) state_nxt = ST_DONE;
        else if (func_r == FUNC_XFORM && rd_max == rd_min) state_nxt = ST_DONE;
        else if (func_r == FUNC_INV && hi_r == lo_r) state_nxt = ST_DONE;
        else state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: if (drsp.done) state_nxt = ST_DONE;
      ST_DONE: if (!ovalid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [32:0] amag, mmag;
  assign amag = a_r[33] ? 33'(-a_r) : a_r[32:0];
  assign mmag = m_r[33] ? 33'(-m_r) : m_r[32:0];

  logic signed [33:0] mn, span, fspan;
  logic [67:0] qclamp;
  logic signed [35:0] sum;
  always_comb begin
    mn = 34'(signed'(rd_min));
    span = 34'(signed'(rd_max)) - mn;
    fspan = 34'(hi_r) - 34'(lo_r);
    wr_en = (state_r == ST_PREP) && (func_r == FUNC_FIT);
    wr_min = (first_r || x_r < signed'(rd_min)) ? x_r : rd_min;
    wr_max = (first_r || x_r > signed'(rd_max)) ? x_r : rd_max;
    dreq.start = (state_r == ST_MUL);
    dreq.dividend = 66'(amag) * 66'(mmag);
    dreq.divisor = d_r[33] ? 33'(-d_r) : d_r[32:0];
    qclamp = (drsp.quotient > 66'h4_0000_0000) ? 68'h4_0000_0000 : {2'b00, drsp.quotient};
    sum = neg_r ? 36'(add_r) - 36'(qclamp) : 36'(add_r) + 36'(qclamp);
    in_ch.ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= func_t'(in_func);
      col_r <= in_column;
      x_r <= in_sample;
      first_r <= in_first;
    end
    if (state_r == ST_PREP) begin
      if ((func_r == FUNC_XFORM || func_r == FUNC_INV) && !fitted_r) begin
        res_r <= '0;
        stat_r <= STAT_NOT_FITTED;
      end else if (func_r == FUNC_XFORM) begin
        res_r <= lo_r;
        stat_r <= STAT_OK;
        a_r <= 34'(x_r) - mn; m_r <= fspan; d_r <= span; add_r <= 34'(lo_r);
        neg_r <= ((34'(x_r) - mn < 0) != (fspan < 0)) != (span < 0);
      end else if (func_r == FUNC_INV) begin
        res_r <= '0;
        stat_r <= (hi_r == lo_r) ? STAT_DIV_ZERO : STAT_OK;
        a_r <= 34'(x_r) - 34'(lo_r); m_r <= span; d_r <= fspan; add_r <= mn;
        neg_r <= ((34'(x_r) - 34'(lo_r) < 0) != (span < 0)) != (fspan < 0);
      end else begin
        res_r <= '0;
        stat_r <= STAT_OK;
      end
    end
    if (state_r == ST_DIV && drsp.done) begin
      if (sum > 36'sh0_7FFF_FFFF) res_r <= 32'h7FFF_FFFF;
      else if (sum < -36'sh0_8000_0000) res_r <= 32'h8000_0000;
      else res_r <= sum[31:0];
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fitted_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) fitted_r <= 1'b1;
      if (state_r == ST_DONE && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  logic signed [DataW-1:0] ores_r;
  status_t ostat_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!ovalid_r || out_ch.ready)) begin
      ores_r <= res_r;
      ostat_r <= stat_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = {ores_r, ostat_r};
endmodule
